FILE: rtl/a2i_pkg.sv
package a2i_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_X      = 8'h78;

	// Digit value of c in the current base; ok is low for a non-digit.
	function automatic digit_t digit_of(logic [7:0] c, logic hex);
		digit_t r;
		logic [7:0] diff;
		r = '0;
		diff = '0;
		if (c inside {[CH_0:CH_9]}) begin
			diff = c - CH_0;
			r.ok = 1'b1;
			r.val = diff[3:0];
		end else if (hex && (c inside {[CH_LA:CH_LF]})) begin
			diff = c - CH_LA + 8'd10;
			r.ok = 1'b1;
			r.val = diff[3:0];
		end else if (hex && (c inside {[CH_UA:CH_UF]})) begin
			diff = c - CH_UA + 8'd10;
			r.ok = 1'b1;
			r.val = diff[3:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/a2i_parse.sv
module a2i_parse #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  a2i_pkg::item_t        item,
	output logic                  emit,
	output logic [VALUE_BITS-1:0] value
);
	import a2i_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_LOOK   = 3'd3;
	localparam logic [2:0] PH_HELD   = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	logic [2:0]            phase_q, phase_d, phase_cur;
	logic                  neg_q, neg_d, neg_cur;
	logic                  hex_q, hex_d, hex_cur;
	logic [VALUE_BITS-1:0] acc_q, acc_d, acc_cur, acc_times;
	logic [7:0]            held_q;
	logic                  held_we;
	digit_t                dc, dh;
	logic [VALUE_BITS-1:0] dc_ext, dh_ext, dh_times;

	// A start flag restarts the parse with this same character.
	assign phase_cur = item.start_req ? PH_LEAD : phase_q;
	assign neg_cur   = item.start_req ? 1'b0 : neg_q;
	assign hex_cur   = item.start_req ? 1'b0 : hex_q;
	assign acc_cur   = item.start_req ? '0 : acc_q;

	assign dc     = digit_of(item.ch, hex_cur);
	assign dh     = digit_of(held_q, hex_cur);
	assign dc_ext = VALUE_BITS'(dc.val);
	assign dh_ext = VALUE_BITS'(dh.val);

	// Constant multiplies are shift-adds.
	assign acc_times = hex_cur ? (acc_cur << 4) : ((acc_cur << 3) + (acc_cur << 1));
	// The accumulator is still zero in the held phase, so the held digit is the whole value.
	assign dh_times  = hex_cur ? (dh_ext << 4) : ((dh_ext << 3) + (dh_ext << 1));

	always_comb begin
		phase_d = phase_cur;
		neg_d   = neg_cur;
		hex_d   = hex_cur;
		acc_d   = acc_cur;
		held_we = 1'b0;
		emit    = 1'b0;
		case (phase_cur)
			PH_LEAD, PH_SIGNED, PH_LOOK: begin
				if ((phase_cur == PH_LEAD) && (item.ch == CH_SPACE)) begin
					phase_d = PH_LEAD;
				end else if ((phase_cur == PH_LEAD) && (item.ch == CH_MINUS)) begin
					neg_d   = 1'b1;
					phase_d = PH_SIGNED;
				end else if ((phase_cur != PH_LOOK) && (item.ch == CH_DOLLAR)) begin
					hex_d   = 1'b1;
					phase_d = PH_LOOK;
				end else if (item.ch == CH_NUL) begin
					emit    = 1'b1;
					phase_d = PH_DONE;
				end else begin
					held_we = 1'b1;
					phase_d = PH_HELD;
				end
			end
			PH_HELD: begin
				if (item.ch == CH_X) begin
					hex_d   = 1'b1;
					phase_d = PH_DIGITS;
				end else if (!dh.ok) begin
					emit    = 1'b1;
					phase_d = PH_DONE;
				end else if (!dc.ok) begin
					acc_d   = dh_ext;
					emit    = 1'b1;
					phase_d = PH_DONE;
				end else begin
					acc_d   = dh_times + dc_ext;
					phase_d = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (!dc.ok) begin
					emit    = 1'b1;
					phase_d = PH_DONE;
				end else begin
					acc_d = acc_times + dc_ext;
				end
			end
			default: begin
				phase_d = phase_cur;
			end
		endcase
	end

	assign value = neg_d ? ('0 - acc_d) : acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			hex_q   <= 1'b0;
			acc_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			hex_q   <= hex_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && held_we) begin
			held_q <= item.ch;
		end
	end

endmodule

FILE: rtl/ascii_to_signed_integer_parser_unit.sv
// Streaming ASCII-to-integer parser: one character per request, start_req on the first
// character of each string. Leading spaces, one '-', a '$' or "0x"-style 'x' hex prefix
// are recognized, and digits accumulate modulo 2^VALUE_BITS. The first non-digit (or NUL
// in the prefix position) produces exactly one result; later characters are dropped until
// the next start_req. Throughput is one character per cycle, set by the registered parse
// state update; while a result waits for out_ready the input stalls. A result is presented
// once the character that ends the number has passed the input register and then the
// result register.
module ascii_to_signed_integer_parser_unit #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            ch,
	input  logic                  start_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] value
);
	import a2i_pkg::*;

	logic                  valid_s1;
	item_t                 item_s1;
	logic                  advance;
	logic                  emit;
	logic [VALUE_BITS-1:0] result;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] value_q;

	// Advance the held request whenever the result slot is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.ch        <= ch;
			item_s1.start_req <= start_req;
		end
	end

	a2i_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.emit   (emit),
		.value  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

FILE: verif/ascii_to_signed_integer_parser_unit_tb.sv
module ascii_to_signed_integer_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import a2i_pkg::*;

	localparam int RANDOM_CHARS = 1150;
	localparam int LONG_HOLD = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIRECTED_ROWS = 25;

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_LEAD,
		PARSE_SIGNED,
		PARSE_LOOK,
		PARSE_HELD,
		PARSE_DIGITS,
		PARSE_DONE
	} parse_phase_e;

	// one directed request; typed rows carry the value the request must produce
	typedef struct packed {
		logic [7:0]  c;
		logic        s;
		logic        typed;
		logic [31:0] v;
	} char_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ch = '0;
	logic        start_req = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] value;

	// travel with the request so the scoreboard sees them at the accepting edge
	logic        typed_result = 1'b0;
	logic [31:0] typed_value = '0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit long_hold_req = 1'b0;
	int parsed_chars = 0;
	int mismatches = 0;

	logic [31:0] expected_values[$];

	parse_phase_e parse_phase = PARSE_IDLE;
	logic        parse_neg = 1'b0;
	logic        parse_hex = 1'b0;
	logic [31:0] parse_acc = '0;
	logic [7:0]  parse_held = '0;

	char_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{"5",       1'b0, 1'b0, 32'd0},
		'{CH_NUL,    1'b1, 1'b1, 32'd0},
		'{"z",       1'b0, 1'b0, 32'd0},
		'{CH_SPACE,  1'b1, 1'b0, 32'd0},
		'{CH_MINUS,  1'b0, 1'b0, 32'd0},
		'{CH_DOLLAR, 1'b0, 1'b0, 32'd0},
		'{"8",       1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{CH_0,      1'b0, 1'b0, 32'd0},
		'{8'hff,     1'b0, 1'b1, 32'h8000_0000},
		'{CH_0,      1'b1, 1'b0, 32'd0},
		'{CH_X,      1'b0, 1'b0, 32'd0},
		'{CH_LA,     1'b0, 1'b0, 32'd0},
		'{"G",       1'b0, 1'b1, 32'd10},
		'{CH_MINUS,  1'b1, 1'b0, 32'd0},
		'{CH_SPACE,  1'b0, 1'b0, 32'd0},
		'{"3",       1'b0, 1'b1, 32'd0},
		'{"1",       1'b1, 1'b0, 32'd0},
		'{"4",       1'b1, 1'b0, 32'd0},
		'{"!",       1'b0, 1'b0, 32'd0}
	};

	ascii_to_signed_integer_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int char_digit(logic [7:0] c, logic hex);
		if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
		if (hex && c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (hex && c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic void shift_in(int d);
		parse_acc = parse_acc * (parse_hex ? 32'd16 : 32'd10) + 32'(d);
	endfunction

	function automatic logic [31:0] close_number();
		parse_phase = PARSE_DONE;
		return parse_neg ? -parse_acc : parse_acc;
	endfunction

	task automatic parse_step(input logic [7:0] c, input logic s, output bit got,
			output logic [31:0] v);
		int d;
		bit to_prefix;
		got = 1'b0;
		v = '0;
		to_prefix = 1'b0;
		if (s) begin
			parse_neg = 1'b0;
			parse_hex = 1'b0;
			parse_acc = '0;
			parse_phase = PARSE_LEAD;
		end
		case (parse_phase)
			PARSE_LEAD: begin
				if (c == CH_MINUS) begin
					parse_neg = 1'b1;
					parse_phase = PARSE_SIGNED;
				end else if (c == CH_DOLLAR) begin
					parse_hex = 1'b1;
					parse_phase = PARSE_LOOK;
				end else if (c != CH_SPACE) begin
					to_prefix = 1'b1;
				end
			end
			PARSE_SIGNED: begin
				if (c == CH_DOLLAR) begin
					parse_hex = 1'b1;
					parse_phase = PARSE_LOOK;
				end else begin
					to_prefix = 1'b1;
				end
			end
			PARSE_LOOK: to_prefix = 1'b1;
			PARSE_HELD: begin
				// an 'x' after the held character drops both and selects hex
				if (c == CH_X) begin
					parse_hex = 1'b1;
					parse_phase = PARSE_DIGITS;
				end else begin
					d = char_digit(parse_held, parse_hex);
					if (d < 0) begin
						got = 1'b1;
						v = close_number();
					end else begin
						shift_in(d);
						d = char_digit(c, parse_hex);
						if (d < 0) begin
							got = 1'b1;
							v = close_number();
						end else begin
							shift_in(d);
							parse_phase = PARSE_DIGITS;
						end
					end
				end
			end
			PARSE_DIGITS: begin
				d = char_digit(c, parse_hex);
				if (d < 0) begin
					got = 1'b1;
					v = close_number();
				end else begin
					shift_in(d);
				end
			end
			default: ;
		endcase
		if (to_prefix) begin
			if (c == CH_NUL) begin
				got = 1'b1;
				v = close_number();
			end else begin
				parse_held = c;
				parse_phase = PARSE_HELD;
			end
		end
	endtask

	always @(posedge clk) begin : scoreboard
		bit got;
		logic [31:0] pv;
		logic [31:0] want;
		if (arst_n && in_valid && in_ready) begin
			parse_step(ch, start_req, got, pv);
			if (typed_result)
				expected_values.push_back(typed_value);
			else if (got)
				expected_values.push_back(pv);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d (0x%08h)",
					$time, $signed(value), value);
				mismatches++;
			end else begin
				want = expected_values.pop_front();
				if (value !== want) begin
					$display("%0t: value mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
						$time, $signed(want), want, $signed(value), value);
					mismatches++;
				end
			end
		end
	end

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: nothing accepted for %0d cycles", $time, quiet);
		$display("Verification failed");
		$finish;
	end

	// returns at the edge that accepts the request; valid stays up for a follow-on
	task automatic offer(input logic [7:0] c, input logic s, input logic typed,
			input logic [31:0] tv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		start_req <= s;
		typed_result <= typed;
		typed_value <= tv;
		do @(posedge clk); while (!in_ready);
		parsed_chars++;
	endtask

	task automatic send_noise();
		logic s;
		repeat ($urandom_range(1, 4)) begin
			s = ($urandom_range(0, 3) == 0);
			offer(8'($urandom_range(0, 255)), s, 1'b0, '0);
		end
	endtask

	task automatic send_string();
		logic [7:0] str[$];
		logic [7:0] c;
		bit hex;
		bit cut;
		int k;
		hex = 1'b0;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
			str.push_back(CH_SPACE);
		if ($urandom_range(0, 2) == 0) str.push_back(CH_MINUS);
		case ($urandom_range(0, 3))
			1: begin
				str.push_back(CH_DOLLAR);
				hex = 1'b1;
			end
			2: begin
				str.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_0);
				str.push_back(CH_X);
				hex = 1'b1;
			end
			default: ;
		endcase
		// long runs of digits can wrap the accumulator
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5)) begin
			k = hex ? $urandom_range(0, 21) : $urandom_range(0, 9);
			if (k < 10)
				str.push_back(CH_0 + 8'(k));
			else if (k < 16)
				str.push_back(CH_LA + 8'(k - 10));
			else
				str.push_back(CH_UA + 8'(k - 16));
		end
		cut = ($urandom_range(0, 9) == 0);
		if (!cut) begin
			if ($urandom_range(0, 3) == 0) begin
				str.push_back(CH_NUL);
			end else begin
				do c = 8'($urandom_range(0, 255)); while (char_digit(c, hex) >= 0);
				str.push_back(c);
			end
		end else begin
			// leave the string unfinished so the next start aborts it
			if (str.size() == 0) str.push_back(CH_0);
			while (str.size() > 1 && $urandom_range(0, 1) == 1) void'(str.pop_back());
		end
		foreach (str[i]) begin
			offer(str[i], i == 0, 1'b0, '0);
		end
		if (!cut) begin
			repeat ($urandom_range(0, 2))
				offer(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		bit hold_done;
		hold_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer(directed_rows[i].c, directed_rows[i].s, directed_rows[i].typed,
				directed_rows[i].v);
		parsed_chars = 0;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 75; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 75; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			while (parsed_chars < (ph + 1) * RANDOM_CHARS / 4) begin
				// keep offering while the receiver holds off, so the block backs up
				if (ph == 0 && !hold_done && parsed_chars > 100) begin
					long_hold_req = 1'b1;
					hold_done = 1'b1;
				end
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_string();
			end
			// drain between phases
			in_valid <= 1'b0;
			@(posedge clk);
			wait (expected_values.size() == 0);
			@(posedge clk);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (expected_values.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_values.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
